[sv/tiled_sum_squared_difference_unit_defines.svh]
`ifndef TILED_SUM_SQUARED_DIFFERENCE_UNIT_DEFINES_SVH
`define TILED_SUM_SQUARED_DIFFERENCE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSSD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tssd check failed");

// next-cycle implication, checked outside reset
`define TSSD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tssd check failed");

`endif

[sv/tssd_pkg.sv]
package tssd_pkg;

  localparam int TILE_ENTRIES = 1024;
  localparam int TILE_SHIFT   = 5;
  localparam int TILE_SIZE    = 1 << TILE_SHIFT;

  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int CHAN_W  = 8;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int IDX_W   = 10;
  localparam int ERR_W   = 28;
  localparam int TOT_W   = 38;

  localparam int TPR_W   = DIM_W + 1 - TILE_SHIFT;
  localparam int TROW_W  = COORD_W - TILE_SHIFT;
  localparam int LIN_W   = TROW_W + TPR_W + 1;
  localparam int TBL_AW  = $clog2(TILE_ENTRIES);

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  cand_blue;
    logic [CHAN_W-1:0]  cand_green;
    logic [CHAN_W-1:0]  cand_red;
    logic [CHAN_W-1:0]  ref_blue;
    logic [CHAN_W-1:0]  ref_green;
    logic [CHAN_W-1:0]  ref_red;
  } pix_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] tile_index;
    logic [ERR_W-1:0] tile_error;
    logic [TOT_W-1:0] total_error;
  } res_out_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             in_range;
    logic [IDX_W-1:0] tile_idx;
    logic [SUM_W-1:0] sq_sum;
  } stage_t;

  typedef struct packed {
    logic             valid;
    logic             in_range;
    logic [IDX_W-1:0] tile_idx;
    logic [ERR_W-1:0] err;
  } tile_req_t;

  typedef struct packed {
    logic     valid;
    res_out_t res;
  } tile_res_t;

endpackage

[sv/tssd_front.sv]
module tssd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             accept_i,
  input  tssd_pkg::pix_in_t pix_i,
  input  tssd_pkg::cfg_t   cfg_i,
  output tssd_pkg::stage_t stage_o
);
  import tssd_pkg::*;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic [DIM_W-1:0]  xe, ye;
  logic              in_img, x_end, y_end;
  logic [DIM_W:0]    wsum;
  logic [TPR_W-1:0]  tpr;
  logic [LIN_W-1:0]  lin_idx;
  logic [SUM_W-1:0]  sum;
  logic              valid_q;
  stage_t            stage_d, stage_q;

  assign xe     = {1'b0, pix_i.pixel_x};
  assign ye     = {1'b0, pix_i.pixel_y};
  assign in_img = (xe < cfg_i.image_width) && (ye < cfg_i.image_height);
  assign x_end  = (xe == cfg_i.image_width - DIM_W'(1)) ||
                  (pix_i.pixel_x[TILE_SHIFT-1:0] == '1);
  assign y_end  = (ye == cfg_i.image_height - DIM_W'(1)) ||
                  (pix_i.pixel_y[TILE_SHIFT-1:0] == '1);

  // tiles per row, rounded up
  assign wsum    = {1'b0, cfg_i.image_width} + (DIM_W + 1)'(TILE_SIZE - 1);
  assign tpr     = wsum[DIM_W:TILE_SHIFT];
  assign lin_idx = LIN_W'(pix_i.pixel_y[COORD_W-1:TILE_SHIFT]) * LIN_W'(tpr)
                 + LIN_W'(pix_i.pixel_x[COORD_W-1:TILE_SHIFT]);

  assign sum = SUM_W'(sq_diff(pix_i.cand_red, pix_i.ref_red))
             + SUM_W'(sq_diff(pix_i.cand_green, pix_i.ref_green))
             + SUM_W'(sq_diff(pix_i.cand_blue, pix_i.ref_blue));

  always_comb begin
    stage_d          = stage_q;
    stage_d.valid    = accept_i && in_img;
    stage_d.last     = x_end && y_end;
    stage_d.in_range = (32'(lin_idx) < 32'(TILE_ENTRIES));
    stage_d.tile_idx = lin_idx[IDX_W-1:0];
    stage_d.sq_sum   = sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

[sv/tssd_table.sv]
module tssd_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  tssd_pkg::tile_req_t req_i,
  output tssd_pkg::tile_res_t res_o,
  output logic                busy_o
);
  import tssd_pkg::*;

  logic [ERR_W-1:0]  mem [TILE_ENTRIES];
  logic [ERR_W-1:0]  rd_q;

  logic              clr_q;
  logic [TBL_AW-1:0] clr_cnt_q;

  logic              v3_q;
  logic              rng3_q;
  logic [IDX_W-1:0]  idx3_q;
  logic [ERR_W-1:0]  err3_q;
  logic              fwd_q;
  logic [ERR_W-1:0]  fwd_data_q;
  logic [TOT_W-1:0]  total_q, total_d;

  logic              re, we, fwd;
  logic [TBL_AW-1:0] wa;
  logic [ERR_W-1:0]  wd, old_err;

  // a write to the same entry in the read cycle is forwarded
  assign fwd = v3_q && rng3_q && (idx3_q[TBL_AW-1:0] == req_i.tile_idx[TBL_AW-1:0]);
  assign re  = adv_i && req_i.valid && req_i.in_range;
  assign we  = clr_q || (adv_i && v3_q && rng3_q);
  assign wa  = clr_q ? clr_cnt_q : idx3_q[TBL_AW-1:0];
  assign wd  = clr_q ? '0 : err3_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[req_i.tile_idx[TBL_AW-1:0]];
    end
  end

  // zero pass over the table after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + TBL_AW'(1);
      if (clr_cnt_q == TBL_AW'(TILE_ENTRIES - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign old_err = fwd_q ? fwd_data_q : rd_q;
  assign total_d = total_q - TOT_W'(old_err) + TOT_W'(err3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q    <= 1'b0;
      total_q <= '0;
    end else if (adv_i) begin
      v3_q <= req_i.valid;
      if (v3_q && rng3_q) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rng3_q     <= req_i.in_range;
      idx3_q     <= req_i.tile_idx;
      err3_q     <= req_i.err;
      fwd_q      <= fwd;
      fwd_data_q <= err3_q;
    end
  end

  assign res_o.valid           = v3_q;
  assign res_o.res.tile_index  = idx3_q;
  assign res_o.res.tile_error  = err3_q;
  assign res_o.res.total_error = rng3_q ? total_d : total_q;
  assign busy_o                = clr_q;

endmodule

[sv/tiled_sum_squared_difference_unit.sv]
// Per-tile sum of squared RGB differences. Takes one pixel pair per cycle while in_stall_o
// is low and, on the last pixel of a clipped 32x32 tile, updates that tile's entry in a
// 1024-entry table if the index is in range, corrects the running total and presents
// tile index, tile error and total once the closing item has passed the front stage
// register, the table stage and the output register. The rate is set by the accumulate
// loop and the table's one read and one write port; back-to-back tiles on the same entry
// are forwarded. After reset the table is zeroed entry by entry, during which in_stall_o
// stays high; configuration writes are taken at any time the block is idle.
`include "tiled_sum_squared_difference_unit_defines.svh"

module tiled_sum_squared_difference_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tssd_pkg::pix_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tssd_pkg::res_out_t              out_data_o,
  input  logic                            cfg_we_i,
  input  tssd_pkg::cfg_idx_e              cfg_index_i,
  input  logic [tssd_pkg::DIM_W-1:0]      cfg_data_i
);
  import tssd_pkg::*;

  cfg_t             cfg_q;
  stage_t           f2;
  tile_req_t        req;
  tile_res_t        tbl_res;
  res_out_t         out_q;
  logic             out_valid_q;
  logic             adv, accept, busy;
  logic [ERR_W-1:0] acc_q, acc_sat;
  logic [ERR_W:0]   acc_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= WIDTH_RST;
      cfg_q.image_height <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // hold only when a result meets a full, stalled output register
  assign adv        = !(out_valid_q && out_stall_i && tbl_res.valid);
  assign in_stall_o = busy || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  tssd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .accept_i (accept),
    .pix_i    (in_data_i),
    .cfg_i    (cfg_q),
    .stage_o  (f2)
  );

  // saturating tile accumulator
  assign acc_sum = {1'b0, acc_q} + (ERR_W + 1)'(f2.sq_sum);
  assign acc_sat = acc_sum[ERR_W] ? '1 : acc_sum[ERR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (adv && f2.valid) begin
      acc_q <= f2.last ? '0 : acc_sat;
    end
  end

  assign req.valid    = adv && f2.valid && f2.last;
  assign req.in_range = f2.in_range;
  assign req.tile_idx = f2.tile_idx;
  assign req.err      = acc_sat;

  tssd_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (req),
    .res_o  (tbl_res),
    .busy_o (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && tbl_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tbl_res.valid) begin
      out_q <= tbl_res.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TSSD_ASSERT_NEXT(a_res_held, !adv, tbl_res.valid && $stable(tbl_res.res))
  `TSSD_ASSERT_NOW(a_out_source, $rose(out_valid_q), $past(tbl_res.valid))
  `TSSD_ASSERT_NEXT(a_acc_clear, adv && f2.valid && f2.last, acc_q == '0)

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import tssd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int STUCK_LIMIT  = 5000;
  localparam int PHASE_PIXELS = 90;

  // one line of the directed script; a dims line carries width and height in x and y
  typedef struct {
    bit          dims;
    int          x;
    int          y;
    logic [47:0] col;
    bit          rnd_col;
    int          reps;
    bit          pinned;
    res_out_t    want;
  } step_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pix_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  res_out_t out_data_o;
  logic     cfg_we_i;
  cfg_idx_e cfg_index_i;
  logic [DIM_W-1:0] cfg_data_i;

  tiled_sum_squared_difference_unit u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  logic [ERR_W-1:0] tile_err_mem [TILE_ENTRIES];
  logic [TOT_W-1:0] total_err;
  logic [ERR_W-1:0] acc_err;
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;

  res_out_t pending_tiles [$];
  res_out_t head;
  int       mismatches;
  int       fed_pixels;
  int       stuck_cycles = 0;
  bit       calm;
  bit       hold_req;
  step_t    script [28];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [SQ_W-1:0] chan_err(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  function automatic bit tile_last(input logic [COORD_W-1:0] c, input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] tile_end;
    tile_end = {1'b0, c} | DIM_W'(TILE_SIZE - 1);
    return {1'b0, c} == ((tile_end < lim - 1'b1) ? tile_end : lim - 1'b1);
  endfunction

  function automatic bit predict_tile(input pix_in_t p, output res_out_t r);
    logic [SUM_W-1:0] sq;
    logic [ERR_W:0]   acc_n;
    logic [TPR_W-1:0] per_row;
    logic [LIN_W-1:0] lin;
    r = '0;
    if ({1'b0, p.pixel_x} >= img_w || {1'b0, p.pixel_y} >= img_h) return 1'b0;
    sq = chan_err(p.cand_red, p.ref_red) + chan_err(p.cand_green, p.ref_green)
       + chan_err(p.cand_blue, p.ref_blue);
    acc_n = {1'b0, acc_err} + sq;
    acc_err = acc_n[ERR_W] ? '1 : acc_n[ERR_W-1:0];
    if (!tile_last(p.pixel_x, img_w) || !tile_last(p.pixel_y, img_h)) return 1'b0;
    per_row = (img_w + TILE_SIZE - 1) >> TILE_SHIFT;
    lin = (p.pixel_y >> TILE_SHIFT) * per_row + (p.pixel_x >> TILE_SHIFT);
    if (lin < TILE_ENTRIES) begin
      total_err = total_err - tile_err_mem[lin[TBL_AW-1:0]] + acc_err;
      tile_err_mem[lin[TBL_AW-1:0]] = acc_err;
    end
    r.tile_index  = lin[IDX_W-1:0];
    r.tile_error  = acc_err;
    r.total_error = total_err;
    acc_err = '0;
    return 1'b1;
  endfunction

  function automatic logic [47:0] rand_colors();
    case ($urandom_range(0, 9))
      0: return 48'hFF_FF_FF_00_00_00;
      1: return 48'h00_00_00_FF_FF_FF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic feed_pixel(input pix_in_t p, input bit pinned, input res_out_t pinned_res);
    res_out_t r;
    bit       closes;
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    if ({1'b0, p.pixel_x} < img_w && {1'b0, p.pixel_y} < img_h) fed_pixels++;
    closes = predict_tile(p, r);
    if (pinned) begin
      pending_tiles.push_back(pinned_res);
    end else if (closes) begin
      pending_tiles.push_back(r);
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    img_w = w;
    img_h = h;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tiles.size() == 0) begin
        flag_mismatch($sformatf("tile result with none pending: %p", out_data_o));
      end else begin
        head = pending_tiles.pop_front();
        if (out_data_o.tile_index !== head.tile_index)
          flag_mismatch($sformatf("tile_index %0d, want %0d",
                                  out_data_o.tile_index, head.tile_index));
        if (out_data_o.tile_error !== head.tile_error)
          flag_mismatch($sformatf("tile_error %0d, want %0d (tile %0d)",
                                  out_data_o.tile_error, head.tile_error, head.tile_index));
        if (out_data_o.total_error !== head.total_error)
          flag_mismatch($sformatf("total_error %0d, want %0d (tile %0d)",
                                  out_data_o.total_error, head.total_error, head.tile_index));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result receiver
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 15);
      end
    end
  end

  initial begin
    int          w;
    int          h;
    int          roll;
    int          tx;
    int          ty;
    int          x0;
    int          y0;
    int          x1;
    int          y1;
    int          sy;
    int          xmax;
    logic [47:0] col;

    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_IMAGE_WIDTH;
    cfg_data_i   <= '0;
    rst_ni       <= 1'b0;
    mismatches    = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    foreach (tile_err_mem[i]) tile_err_mem[i] = '0;
    total_err = '0;
    acc_err   = '0;
    img_w     = WIDTH_RST;
    img_h     = HEIGHT_RST;

    script = '{
      // default 640x480 image
      '{0, 639, 479, 48'h00_00_03_00_00_00, 0, 1, 1, '{10'd299, 28'd9, 38'd9}},
      '{0, 640, 0, 48'hFF_FF_FF_00_00_00, 0, 1, 1'b0, '0},
      '{0, 0, 480, 48'hFF_FF_FF_00_00_00, 0, 1, 1'b0, '0},
      // single pixel image
      '{1, 1, 1, '0, 0, 0, 1'b0, '0},
      '{0, 0, 0, 48'h00_00_FF_00_00_00, 0, 1, 1, '{10'd0, 28'd65025, 38'd65034}},
      '{0, 1, 0, 48'hFF_FF_FF_00_00_00, 0, 1, 1'b0, '0},
      '{0, 0, 1, 48'hFF_FF_FF_00_00_00, 0, 1, 1'b0, '0},
      '{0, 0, 0, 48'hFF_FF_FF_00_00_00, 0, 1, 1, '{10'd0, 28'd195075, 38'd195084}},
      '{0, 0, 0, 48'h00_00_00_FF_FF_FF, 0, 1, 1, '{10'd0, 28'd195075, 38'd195084}},
      '{0, 0, 0, 48'h5A_5A_5A_5A_5A_5A, 0, 1, 1, '{10'd0, 28'd0, 38'd9}},
      // full size image, saturating accumulator
      '{1, 1024, 1024, '0, 0, 0, 1'b0, '0},
      '{0, 0, 0, 48'hFF_FF_FF_00_00_00, 0, 1400, 1'b0, '0},
      '{0, 31, 31, 48'hFF_FF_FF_00_00_00, 0, 1, 1, '{10'd0, 28'hFFF_FFFF, 38'd268435464}},
      '{0, 1023, 1023, 48'hFF_FF_FF_FF_FF_FF, 0, 1, 1, '{10'd1023, 28'd0, 38'd268435464}},
      '{0, 1023, 1023, 48'h01_00_00_00_00_00, 0, 1, 1, '{10'd1023, 28'd1, 38'd268435465}},
      // tile index past the table
      '{1, 2047, 1024, '0, 0, 0, 1'b0, '0},
      '{0, 1023, 1023, 48'h00_02_00_00_00_00, 0, 1, 1, '{10'd991, 28'd4, 38'd268435465}},
      // zero height
      '{1, 2047, 0, '0, 0, 0, 1'b0, '0},
      '{0, 0, 0, 48'hFF_FF_FF_00_00_00, 0, 1, 1'b0, '0},
      '{0, 1023, 1023, 48'hFF_FF_FF_00_00_00, 0, 1, 1'b0, '0},
      // out of tile order
      '{1, 64, 64, '0, 0, 0, 1'b0, '0},
      '{0, 5, 5, 48'h00_00_03_00_00_00, 0, 1, 1'b0, '0},
      '{0, 63, 63, 48'h00_00_01_00_00_00, 0, 1, 1, '{10'd3, 28'd10, 38'd268435475}},
      // clipped edge tiles
      '{1, 40, 40, '0, 0, 0, 1'b0, '0},
      '{0, 39, 31, '0, 1, 1, 1'b0, '0},
      '{0, 31, 39, '0, 1, 1, 1'b0, '0},
      '{0, 39, 39, '0, 1, 1, 1'b0, '0},
      '{0, 1023, 0, '0, 1, 1, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].dims) begin
        set_image(DIM_W'(script[i].x), DIM_W'(script[i].y));
      end else begin
        for (int n = 0; n < script[i].reps; n++) begin
          col = script[i].rnd_col ? rand_colors() : script[i].col;
          feed_pixel({COORD_W'(script[i].x), COORD_W'(script[i].y), col},
                     script[i].pinned, script[i].want);
        end
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin w = 1;    h = 1;    end
        1: begin w = 1024; h = 1024; end
        2: begin w = 1024; h = 1;    end
        3: begin w = 1;    h = 1024; end
        4: begin w = 2047; h = $urandom_range(513, 1024); end
        default: begin
          w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 160);
          h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 160);
        end
      endcase
      set_image(DIM_W'(w), DIM_W'(h));
      calm = (ph == 6);
      if (ph == 0) hold_req = 1'b1;
      xmax = ((w > 1024) ? 1024 : w) - 1;
      fed_pixels = 0;
      while (fed_pixels < PHASE_PIXELS) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          // one tile in raster order, only its tail rows when it is large
          tx = $urandom_range(0, (xmax >> TILE_SHIFT));
          ty = $urandom_range(0, ((h - 1) >> TILE_SHIFT));
          x0 = tx * TILE_SIZE;
          y0 = ty * TILE_SIZE;
          x1 = (x0 + TILE_SIZE - 1 > w - 1) ? w - 1 : x0 + TILE_SIZE - 1;
          y1 = (y0 + TILE_SIZE - 1 > h - 1) ? h - 1 : y0 + TILE_SIZE - 1;
          sy = y0;
          if ((x1 - x0 + 1) * (y1 - y0 + 1) > 160) sy = y1 - 96 / (x1 - x0 + 1) + 1;
          for (int yy = sy; yy <= y1; yy++) begin
            for (int xx = x0; xx <= x1; xx++) begin
              feed_pixel({COORD_W'(xx), COORD_W'(yy), rand_colors()}, 1'b0, '0);
            end
          end
        end else if (roll < 85) begin
          repeat ($urandom_range(1, 4)) begin
            feed_pixel({COORD_W'($urandom), COORD_W'($urandom), rand_colors()}, 1'b0, '0);
          end
        end else begin
          repeat ($urandom_range(1, 6)) begin
            feed_pixel({COORD_W'($urandom_range(0, xmax)), COORD_W'($urandom_range(0, h - 1)),
                        rand_colors()}, 1'b0, '0);
          end
        end
      end
    end
    calm = 1'b0;

    quiesce();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/tssd_pkg.sv
sv/tssd_front.sv
sv/tssd_table.sv
sv/tiled_sum_squared_difference_unit.sv
dv/testbench.sv
